// ===== hw/rtl/etsp_pkg.sv =====
// Shared types, constants and a helper function for the event time-surface patch block.
// Depends on nothing; every other RTL file of the block refers to it by scoped names.
`default_nettype none

package etsp_pkg;

    // Sensor and history geometry.
    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int DEPTH       = 4;
    localparam int MAX_RADIUS  = 3;

    // Field widths.
    localparam int TS_W        = 32;
    localparam int COORD_W     = 7;
    localparam int SIZE_W      = 8;
    localparam int RAD_W       = 2;
    localparam int POS_W       = 6;
    localparam int LAYER_W     = 16;
    localparam int LAYERS      = 8;
    localparam int HALF_LAYERS = 4;
    localparam int SLOT_W      = 3;

    // History memory: one row per pixel holds both polarities, DEPTH words each.
    localparam int ROWS        = MAX_WIDTH * MAX_HEIGHT;
    localparam int ROW_AW      = $clog2(ROWS);
    localparam int ENTRIES     = 2 * DEPTH;

    // Log unit: input is d+1 (up to 2^32), output is log2 in Q6.16.
    localparam int LOG_IN_W    = 33;
    localparam int LOG_W       = 22;
    localparam int LN2_Q16     = 45426;

    // Event queue between front and engine.
    localparam int FIFO_DEPTH  = 2;

    // Configuration port.
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_WIDTH  = 3'd0,
        REG_SENSOR_HEIGHT = 3'd1,
        REG_RADIUS        = 3'd2,
        REG_MAX_TIME      = 3'd3,
        REG_MIN_TIME      = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] sensor_width;
        logic [SIZE_W-1:0] sensor_height;
        logic [RAD_W-1:0]  radius;
        logic [TS_W-1:0]   max_time;
        logic [TS_W-1:0]   min_time;
    } cfg_t;

    typedef struct packed {
        logic [TS_W-1:0]    ts;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               pol;
    } event_t;

    typedef struct packed {
        logic              is_lmin;
        logic [SLOT_W-1:0] slot;
    } log_tag_t;

    typedef struct packed {
        logic [POS_W-1:0]                  position_index;
        logic [LAYERS-1:0][LAYER_W-1:0]    layer;
        logic                              last_of_patch;
    } result_t;

    // Sensor size in use: the register value clamped to 1..cap.
    function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] size_val,
                                                   logic [SIZE_W-1:0] cap);
        logic [SIZE_W-1:0] res;
        if (size_val == '0) begin
            res = SIZE_W'(1);
        end else if (size_val > cap) begin
            res = cap;
        end else begin
            res = size_val;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/event_time_surface_patch.sv =====
// Top level of the event time-surface patch block: configuration registers and wiring.
// Depends on etsp_pkg, etsp_front, etsp_fifo and etsp_engine (which holds etsp_log).
//
// Usage. Events (timestamp, x_coord, y_coord, polarity) arrive as beats on the in_valid /
// in_ready channel. For each event the block sends (2*radius+1)^2 result beats on the
// out_valid / out_ready channel, one per window position in column-major walk order, the
// last one flagged by last_of_patch. Each beat carries eight Q5.11 surface values.
// Processing. An event first takes the log of the offset, then each window position in turn,
// then a read and a write to push the new timestamp into the history. The pace is set by the
// single pipelined log unit (22 stages, one operand a cycle) and one window position in flight.
// The front and a two-beat queue keep taking events while the engine works on an older one.
// Reset. After rst_n rises the engine clears the history memory, one row a cycle; in_ready
// stays low while it clears. Configuration writes are taken anytime.
// Stalls. A result beat waits in the output register while out_ready is low; the engine
// finishes the next window position into its gather buffer and then waits for the slot.
`default_nettype none

module event_time_surface_patch (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [etsp_pkg::TS_W-1:0]         timestamp,
    input  wire logic [etsp_pkg::COORD_W-1:0]      x_coord,
    input  wire logic [etsp_pkg::COORD_W-1:0]      y_coord,
    input  wire logic                              polarity,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [etsp_pkg::POS_W-1:0]             position_index,
    output logic [etsp_pkg::LAYER_W-1:0]           layer_0,
    output logic [etsp_pkg::LAYER_W-1:0]           layer_1,
    output logic [etsp_pkg::LAYER_W-1:0]           layer_2,
    output logic [etsp_pkg::LAYER_W-1:0]           layer_3,
    output logic [etsp_pkg::LAYER_W-1:0]           layer_4,
    output logic [etsp_pkg::LAYER_W-1:0]           layer_5,
    output logic [etsp_pkg::LAYER_W-1:0]           layer_6,
    output logic [etsp_pkg::LAYER_W-1:0]           layer_7,
    output logic                                   last_of_patch,
    input  wire logic                              cfg_we,
    input  wire logic [etsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [etsp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers. A write to an index past the list is dropped.
    etsp_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_width  <= etsp_pkg::SIZE_W'(128);
            cfg_reg.sensor_height <= etsp_pkg::SIZE_W'(128);
            cfg_reg.radius        <= etsp_pkg::RAD_W'(3);
            cfg_reg.max_time      <= etsp_pkg::TS_W'(1000000);
            cfg_reg.min_time      <= etsp_pkg::TS_W'(1000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                etsp_pkg::REG_SENSOR_WIDTH:  cfg_reg.sensor_width  <= cfg_data[7:0];
                etsp_pkg::REG_SENSOR_HEIGHT: cfg_reg.sensor_height <= cfg_data[7:0];
                etsp_pkg::REG_RADIUS:        cfg_reg.radius        <= cfg_data[1:0];
                etsp_pkg::REG_MAX_TIME:      cfg_reg.max_time      <= cfg_data;
                etsp_pkg::REG_MIN_TIME:      cfg_reg.min_time      <= cfg_data;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    etsp_pkg::event_t  in_event;
    etsp_pkg::event_t  fq_event;
    etsp_pkg::event_t  eng_event;
    etsp_pkg::result_t result;
    logic              fq_valid;
    logic              fq_ready;
    logic              eng_valid;
    logic              eng_ready;
    logic              clearing;

    assign in_event.ts  = timestamp;
    assign in_event.x   = x_coord;
    assign in_event.y   = y_coord;
    assign in_event.pol = polarity;

    etsp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_event (in_event),
        .cfg      (cfg_reg),
        .hold     (clearing),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_event  (fq_event)
    );

    etsp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_event),
        .pop_valid  (eng_valid),
        .pop_ready  (eng_ready),
        .pop_data   (eng_event)
    );

    etsp_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ev_valid  (eng_valid),
        .ev_ready  (eng_ready),
        .ev        (eng_event),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign position_index = result.position_index;
    assign layer_0        = result.layer[0];
    assign layer_1        = result.layer[1];
    assign layer_2        = result.layer[2];
    assign layer_3        = result.layer[3];
    assign layer_4        = result.layer[4];
    assign layer_5        = result.layer[5];
    assign layer_6        = result.layer[6];
    assign layer_7        = result.layer[7];
    assign last_of_patch  = result.last_of_patch;

endmodule

`default_nettype wire

// ===== hw/rtl/etsp_log.sv =====
// Pipelined fixed-point log2 unit: leading-one normalization then sixteen squaring stages.
// Depends on etsp_pkg for widths and the tag type; one operand enters per cycle.
`default_nettype none

module etsp_log (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic [etsp_pkg::LOG_IN_W-1:0]     in_a,
    input  wire etsp_pkg::log_tag_t                in_tag,
    output logic                                   out_valid,
    output logic [etsp_pkg::LOG_W-1:0]             out_la,
    output etsp_pkg::log_tag_t                     out_tag
);

    localparam int NORM_STAGES = 5;
    localparam int SQ_STAGES   = 16;
    localparam int LAST        = NORM_STAGES + SQ_STAGES;

    logic [LAST:0]         valid_reg;
    logic [31:0]           m_reg    [0:LAST];
    logic [5:0]            n_reg    [0:LAST];
    logic [15:0]           frac_reg [0:LAST];
    etsp_pkg::log_tag_t    tag_reg  [0:LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAST-1:0], in_valid};
        end
    end

    // Stage 0: the one value that reaches bit 32 (2^32) is pre-shifted.
    always_ff @(posedge clk)
    begin
        m_reg[0]    <= in_a[32] ? in_a[32:1] : in_a[31:0];
        n_reg[0]    <= in_a[32] ? 6'd32 : 6'd31;
        frac_reg[0] <= '0;
        tag_reg[0]  <= in_tag;
    end

    // Normalization: shift by 16, 8, 4, 2, 1 while the top bits are clear.
    for (genvar s = 1; s <= NORM_STAGES; s++)
    begin : g_norm
        localparam int SH = 16 >> (s - 1);
        always_ff @(posedge clk)
        begin
            if (m_reg[s-1][31 -: SH] == '0)
            begin
                m_reg[s] <= m_reg[s-1] << SH;
                n_reg[s] <= n_reg[s-1] - 6'(SH);
            end
            else
            begin
                m_reg[s] <= m_reg[s-1];
                n_reg[s] <= n_reg[s-1];
            end
            frac_reg[s] <= frac_reg[s-1];
            tag_reg[s]  <= tag_reg[s-1];
        end
    end

    // Fraction bits: square the Q31 mantissa; an overflow past 2.0 yields a one bit.
    for (genvar s = NORM_STAGES + 1; s <= LAST; s++)
    begin : g_sq
        logic [63:0] prod;
        logic [32:0] sq;
        assign prod = m_reg[s-1] * m_reg[s-1];
        assign sq   = prod[63:31];
        always_ff @(posedge clk)
        begin
            m_reg[s]    <= sq[32] ? sq[32:1] : sq[31:0];
            n_reg[s]    <= n_reg[s-1];
            frac_reg[s] <= {frac_reg[s-1][14:0], sq[32]};
            tag_reg[s]  <= tag_reg[s-1];
        end
    end

    assign out_valid = valid_reg[LAST];
    assign out_la    = {n_reg[LAST], frac_reg[LAST]};
    assign out_tag   = tag_reg[LAST];

endmodule

`default_nettype wire

// ===== hw/rtl/etsp_engine.sv =====
// Patch engine: walks the window, reads pixel histories, computes surfaces, pushes history.
// Depends on etsp_pkg and instantiates etsp_log; holds the history memory.
`default_nettype none

module etsp_engine (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire etsp_pkg::cfg_t        cfg,
    input  wire logic                  ev_valid,
    output logic                       ev_ready,
    input  wire etsp_pkg::event_t      ev,
    output logic                       clearing,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output etsp_pkg::result_t          result
);

    localparam int EW = $clog2(etsp_pkg::ENTRIES);
    localparam int CW = $clog2(etsp_pkg::ENTRIES + 1);

    typedef logic [etsp_pkg::ENTRIES-1:0][etsp_pkg::TS_W-1:0] hrow_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LMIN_ISSUE,
        ST_LMIN_WAIT,
        ST_NB_SETUP,
        ST_NB_READ,
        ST_NB_ISSUE,
        ST_NB_WAIT,
        ST_WB_READ,
        ST_WB_WRITE
    } state_t;

    state_t                             state_reg;
    logic [etsp_pkg::ROW_AW-1:0]        clr_cnt_reg;
    etsp_pkg::event_t                   ev_reg;
    logic [etsp_pkg::LOG_W-1:0]         lmin_reg;
    logic [2:0]                         ci_reg;
    logic [2:0]                         cj_reg;
    logic [etsp_pkg::POS_W-1:0]         k_reg;
    logic [EW-1:0]                      e_reg;
    logic [etsp_pkg::ROW_AW-1:0]        addr_reg;
    logic                               out_valid_reg;
    etsp_pkg::result_t                  result_reg;

    // History memory, one write and one read port.
    hrow_t                              mem [0:etsp_pkg::ROWS-1];
    hrow_t                              rd_row_reg;
    logic                               mem_we;
    logic                               mem_re;
    logic [etsp_pkg::ROW_AW-1:0]        mem_addr;
    hrow_t                              mem_wdata;
    hrow_t                              wb_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_row_reg <= mem[mem_addr];
        end
    end

    // Window geometry.
    logic [etsp_pkg::RAD_W-1:0]   r_eff;
    logic [2:0]                   two_r;
    logic [etsp_pkg::SIZE_W-1:0]  w_eff;
    logic [etsp_pkg::SIZE_W-1:0]  h_eff;
    logic signed [9:0]            xc;
    logic signed [9:0]            yc;
    logic [etsp_pkg::COORD_W-1:0] xn;
    logic [etsp_pkg::COORD_W-1:0] yn;
    logic [etsp_pkg::ROW_AW-1:0]  nb_addr;
    logic [etsp_pkg::ROW_AW-1:0]  center_addr;
    logic                         last_nb;

    function automatic logic [etsp_pkg::COORD_W-1:0] fold(logic signed [9:0] c,
                                                          logic [etsp_pkg::SIZE_W-1:0] size);
        logic signed [10:0] v;
        logic signed [10:0] s;
        s = $signed({3'b000, size});
        v = 11'(c);
        if (v < 11'sd0)
        begin
            v = -v;
        end
        else if (v >= s)
        begin
            v = 11'(s + s - v - 11'sd1);
        end
        if (v < 11'sd0)
        begin
            v = 11'sd0;
        end
        if (v >= s)
        begin
            v = 11'(s - 11'sd1);
        end
        return v[etsp_pkg::COORD_W-1:0];
    endfunction

    assign r_eff = (cfg.radius > etsp_pkg::RAD_W'(etsp_pkg::MAX_RADIUS))
                 ? etsp_pkg::RAD_W'(etsp_pkg::MAX_RADIUS) : cfg.radius;
    assign two_r = {r_eff, 1'b0};
    assign w_eff = etsp_pkg::eff_size(cfg.sensor_width,
                                      etsp_pkg::SIZE_W'(etsp_pkg::MAX_WIDTH));
    assign h_eff = etsp_pkg::eff_size(cfg.sensor_height,
                                      etsp_pkg::SIZE_W'(etsp_pkg::MAX_HEIGHT));
    assign xc = $signed({3'b000, ev_reg.x}) + $signed({7'b0, ci_reg}) - $signed({8'b0, r_eff});
    assign yc = $signed({3'b000, ev_reg.y}) + $signed({7'b0, cj_reg}) - $signed({8'b0, r_eff});
    assign xn = fold(xc, w_eff);
    assign yn = fold(yc, h_eff);
    assign nb_addr = etsp_pkg::ROW_AW'(etsp_pkg::ROW_AW'(xn)
                   * etsp_pkg::ROW_AW'(etsp_pkg::MAX_HEIGHT) + etsp_pkg::ROW_AW'(yn));
    assign center_addr = etsp_pkg::ROW_AW'(etsp_pkg::ROW_AW'(ev_reg.x)
                       * etsp_pkg::ROW_AW'(etsp_pkg::MAX_HEIGHT) + etsp_pkg::ROW_AW'(ev_reg.y));
    assign last_nb = (ci_reg == two_r) && (cj_reg == two_r);

    // Entry selection for the value being issued to the log unit.
    logic                           half;
    logic [EW-1:0]                  d_idx;
    logic [etsp_pkg::SLOT_W-1:0]    slot;
    logic                           pol_sel;
    logic [EW-1:0]                  widx;
    logic [etsp_pkg::TS_W-1:0]      old;
    logic [etsp_pkg::TS_W-1:0]      diff;
    logic [etsp_pkg::TS_W-1:0]      dsel;
    logic                           log_in_valid;
    logic [etsp_pkg::LOG_IN_W-1:0]  log_in_a;
    etsp_pkg::log_tag_t             log_in_tag;
    logic                           log_out_valid;
    logic [etsp_pkg::LOG_W-1:0]     log_out_la;
    etsp_pkg::log_tag_t             log_out_tag;

    always_comb
    begin
        half    = ({1'b0, e_reg} >= (EW + 1)'(etsp_pkg::DEPTH));
        d_idx   = half ? EW'(e_reg - EW'(etsp_pkg::DEPTH)) : e_reg;
        slot    = half ? etsp_pkg::SLOT_W'(etsp_pkg::SLOT_W'(etsp_pkg::HALF_LAYERS)
                                           + etsp_pkg::SLOT_W'(d_idx))
                       : etsp_pkg::SLOT_W'(d_idx);
        pol_sel = ev_reg.pol ^ half;
        widx    = pol_sel ? EW'(EW'(etsp_pkg::DEPTH) + d_idx) : d_idx;
        old     = rd_row_reg[widx];
        diff    = ev_reg.ts - old;
        if (old == '0 || old > ev_reg.ts)
        begin
            dsel = cfg.max_time;
        end
        else if (diff >= cfg.max_time)
        begin
            dsel = cfg.max_time;
        end
        else
        begin
            dsel = diff;
        end

        log_in_valid = (state_reg == ST_LMIN_ISSUE) || (state_reg == ST_NB_ISSUE);
        if (state_reg == ST_LMIN_ISSUE)
        begin
            log_in_a           = etsp_pkg::LOG_IN_W'(cfg.min_time) + etsp_pkg::LOG_IN_W'(1);
            log_in_tag.is_lmin = 1'b1;
            log_in_tag.slot    = '0;
        end
        else
        begin
            log_in_a           = etsp_pkg::LOG_IN_W'(dsel) + etsp_pkg::LOG_IN_W'(1);
            log_in_tag.is_lmin = 1'b0;
            log_in_tag.slot    = slot;
        end
    end

    etsp_log u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (log_in_valid),
        .in_a      (log_in_a),
        .in_tag    (log_in_tag),
        .out_valid (log_out_valid),
        .out_la    (log_out_la),
        .out_tag   (log_out_tag)
    );

    // Surface: (log difference * ln2 + half) >> 21, saturated, gathered per neighbour.
    logic                            sv_valid_reg;
    logic [37:0]                     prod_reg;
    logic [etsp_pkg::SLOT_W-1:0]     sv_slot_reg;
    logic [etsp_pkg::LAYER_W-1:0]    layer_buf [0:etsp_pkg::LAYERS-1];
    logic [CW-1:0]                   coll_cnt_reg;
    logic [etsp_pkg::LOG_W-1:0]      dlog;
    logic [38:0]                     rounded;
    logic [17:0]                     shifted;
    logic [etsp_pkg::LAYER_W-1:0]    sat;
    logic                            nb_clear;

    assign dlog     = (log_out_la > lmin_reg) ? etsp_pkg::LOG_W'(log_out_la - lmin_reg) : '0;
    assign rounded  = 39'(prod_reg) + 39'(1 << 20);
    assign shifted  = rounded[38:21];
    assign sat      = (shifted > 18'(16'hFFFF)) ? 16'hFFFF : shifted[15:0];
    assign nb_clear = (state_reg == ST_NB_SETUP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_valid_reg <= 1'b0;
            coll_cnt_reg <= '0;
        end
        else
        begin
            sv_valid_reg <= log_out_valid && !log_out_tag.is_lmin;
            if (nb_clear)
            begin
                coll_cnt_reg <= '0;
            end
            else if (sv_valid_reg)
            begin
                coll_cnt_reg <= coll_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= 38'(dlog) * 38'(etsp_pkg::LN2_Q16);
        sv_slot_reg <= log_out_tag.slot;
        if (nb_clear)
        begin
            for (int i = 0; i < etsp_pkg::LAYERS; i++)
            begin
                layer_buf[i] <= '0;
            end
        end
        else if (sv_valid_reg)
        begin
            layer_buf[sv_slot_reg] <= sat;
        end
    end

    // New center row: the event's polarity shifts down one place, the other is kept.
    always_comb
    begin
        for (int q = 0; q < 2; q++)
        begin
            for (int dd = 0; dd < etsp_pkg::DEPTH; dd++)
            begin
                if ((q == 1) == ev_reg.pol)
                begin
                    wb_row[q*etsp_pkg::DEPTH+dd] = (dd == 0) ? ev_reg.ts
                        : rd_row_reg[q*etsp_pkg::DEPTH + dd - ((dd == 0) ? 0 : 1)];
                end
                else
                begin
                    wb_row[q*etsp_pkg::DEPTH+dd] = rd_row_reg[q*etsp_pkg::DEPTH+dd];
                end
            end
        end
    end

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WB_WRITE);
    assign mem_re    = (state_reg == ST_NB_READ) || (state_reg == ST_WB_READ);
    assign mem_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : wb_row;

    logic put_ok;
    assign put_ok = (coll_cnt_reg == CW'(etsp_pkg::ENTRIES)) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            ev_reg        <= '0;
            lmin_reg      <= '0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            k_reg         <= '0;
            e_reg         <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            // The slot empties when its beat is taken and no new beat replaces it.
            if (out_valid_reg && out_ready && !(state_reg == ST_NB_WAIT && put_ok))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + etsp_pkg::ROW_AW'(1);
                    if (clr_cnt_reg == etsp_pkg::ROW_AW'(etsp_pkg::ROWS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (ev_valid)
                    begin
                        ev_reg    <= ev;
                        state_reg <= ST_LMIN_ISSUE;
                    end
                end
                ST_LMIN_ISSUE:
                begin
                    state_reg <= ST_LMIN_WAIT;
                end
                ST_LMIN_WAIT:
                begin
                    if (log_out_valid && log_out_tag.is_lmin)
                    begin
                        lmin_reg  <= log_out_la;
                        ci_reg    <= '0;
                        cj_reg    <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_NB_SETUP;
                    end
                end
                ST_NB_SETUP:
                begin
                    addr_reg  <= nb_addr;
                    state_reg <= ST_NB_READ;
                end
                ST_NB_READ:
                begin
                    e_reg     <= '0;
                    state_reg <= ST_NB_ISSUE;
                end
                ST_NB_ISSUE:
                begin
                    e_reg <= e_reg + EW'(1);
                    if (e_reg == EW'(etsp_pkg::ENTRIES - 1))
                    begin
                        state_reg <= ST_NB_WAIT;
                    end
                end
                ST_NB_WAIT:
                begin
                    if (put_ok)
                    begin
                        out_valid_reg             <= 1'b1;
                        result_reg.position_index <= k_reg;
                        result_reg.last_of_patch  <= last_nb;
                        for (int i = 0; i < etsp_pkg::LAYERS; i++)
                        begin
                            result_reg.layer[i] <= layer_buf[i];
                        end
                        if (last_nb)
                        begin
                            addr_reg  <= center_addr;
                            state_reg <= ST_WB_READ;
                        end
                        else
                        begin
                            if (cj_reg == two_r)
                            begin
                                cj_reg <= '0;
                                ci_reg <= ci_reg + 3'd1;
                            end
                            else
                            begin
                                cj_reg <= cj_reg + 3'd1;
                            end
                            k_reg     <= k_reg + etsp_pkg::POS_W'(1);
                            state_reg <= ST_NB_SETUP;
                        end
                    end
                end
                ST_WB_READ:
                begin
                    state_reg <= ST_WB_WRITE;
                end
                ST_WB_WRITE:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign ev_ready  = (state_reg == ST_IDLE);
    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

`ifndef SYNTH
    a_pipe_empty_at_setup: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NB_SETUP |-> !log_out_valid && !sv_valid_reg)
        else $error("log pipeline not drained at neighbour start");

    a_lmin_when_waited: assert property (@(posedge clk) disable iff (!rst_n)
        log_out_valid && log_out_tag.is_lmin |-> state_reg == ST_LMIN_WAIT)
        else $error("offset log returned outside its wait");

    a_collect_bound: assert property (@(posedge clk) disable iff (!rst_n)
        coll_cnt_reg <= CW'(etsp_pkg::ENTRIES))
        else $error("more surface values than entries");

    a_last_to_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NB_WAIT && put_ok && last_nb |=> state_reg == ST_WB_READ)
        else $error("history not written after final neighbour");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/etsp_fifo.sv =====
// Short event queue between the front and the patch engine.
// Depends on etsp_pkg for the event type and depth.
`default_nettype none

module etsp_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire etsp_pkg::event_t  push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output etsp_pkg::event_t       pop_data
);

    localparam int PTR_W = $clog2(etsp_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(etsp_pkg::FIFO_DEPTH + 1);

    etsp_pkg::event_t   entries_reg [0:etsp_pkg::FIFO_DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_W'(etsp_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/etsp_front.sv =====
// Input front: takes event beats, clamps coordinates into the sensor, stages them for the queue.
// Depends on etsp_pkg for the event and configuration types.
`default_nettype none

module etsp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire etsp_pkg::event_t  in_event,
    input  wire etsp_pkg::cfg_t    cfg,
    input  wire logic              hold,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output etsp_pkg::event_t       q_event
);

    logic                         valid_reg;
    etsp_pkg::event_t             ev_reg;
    etsp_pkg::event_t             clamped;
    logic [etsp_pkg::SIZE_W-1:0]  w_eff;
    logic [etsp_pkg::SIZE_W-1:0]  h_eff;

    assign w_eff = etsp_pkg::eff_size(cfg.sensor_width,
                                      etsp_pkg::SIZE_W'(etsp_pkg::MAX_WIDTH));
    assign h_eff = etsp_pkg::eff_size(cfg.sensor_height,
                                      etsp_pkg::SIZE_W'(etsp_pkg::MAX_HEIGHT));

    // An event outside the sensor is moved onto its last column or row.
    always_comb
    begin
        clamped = in_event;
        if (etsp_pkg::SIZE_W'(in_event.x) >= w_eff)
        begin
            clamped.x = etsp_pkg::COORD_W'(w_eff - etsp_pkg::SIZE_W'(1));
        end
        if (etsp_pkg::SIZE_W'(in_event.y) >= h_eff)
        begin
            clamped.y = etsp_pkg::COORD_W'(h_eff - etsp_pkg::SIZE_W'(1));
        end
    end

    assign in_ready = !hold && (!valid_reg || q_ready);
    assign q_valid  = valid_reg;
    assign q_event  = ev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (q_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ev_reg <= clamped;
        end
    end

endmodule

`default_nettype wire
